// ----- hw/rtl/lrast_pkg.sv -----
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared constants and types for the line rasterizer.
// ----------------------------------------------------------------------------
package lrast_pkg;

    // fixed field widths
    localparam int FRAME_DIM_BITS = 12;
    localparam int ADDR_BITS      = 22;
    localparam int COLOUR_BITS    = 32;
    localparam int CFG_IDX_BITS   = 1;

    // command opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    // configuration reset values
    localparam logic [FRAME_DIM_BITS-1:0] FRAME_WIDTH_RESET  = 12'd1280;
    localparam logic [FRAME_DIM_BITS-1:0] FRAME_HEIGHT_RESET = 12'd720;

    typedef logic [FRAME_DIM_BITS-1:0] t_frame_dim;
    typedef logic [ADDR_BITS-1:0]      t_addr;
    typedef logic [COLOUR_BITS-1:0]    t_colour;
    typedef logic [CFG_IDX_BITS-1:0]   t_cfg_idx;

    // frame geometry handed to the clip stage
    typedef struct packed {
        t_frame_dim width;
        t_frame_dim height;
    } t_frame_cfg;

endpackage

// ----- hw/rtl/lrast_in_if.sv -----
// ----------------------------------------------------------------------------
// lrast_in_if
// Command channel: start or tick words with endpoints and colour.
// ----------------------------------------------------------------------------
interface lrast_in_if #(
    parameter int COORD_BITS = 12
);
    logic                                    valid;
    logic                                    ready;
    logic                                    opcode;
    logic signed [COORD_BITS-1:0]            start_x;
    logic signed [COORD_BITS-1:0]            start_y;
    logic signed [COORD_BITS-1:0]            end_x;
    logic signed [COORD_BITS-1:0]            end_y;
    logic [lrast_pkg::COLOUR_BITS-1:0]       line_colour;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, line_colour,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, line_colour,
        output ready
    );
endinterface

// ----- hw/rtl/lrast_out_if.sv -----
// ----------------------------------------------------------------------------
// lrast_out_if
// Pixel channel: one framebuffer write word per rasterized pixel.
// ----------------------------------------------------------------------------
interface lrast_out_if #(
    parameter int COORD_BITS = 12
);
    logic                                    valid;
    logic                                    ready;
    logic                                    write_enable;
    logic signed [COORD_BITS-1:0]            pixel_x;
    logic signed [COORD_BITS-1:0]            pixel_y;
    logic [lrast_pkg::ADDR_BITS-1:0]         pixel_address;
    logic [lrast_pkg::COLOUR_BITS-1:0]       pixel_colour;
    logic                                    last_pixel;

    modport source (
        output valid, write_enable, pixel_x, pixel_y, pixel_address,
               pixel_colour, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, write_enable, pixel_x, pixel_y, pixel_address,
               pixel_colour, last_pixel,
        output ready
    );
endinterface

// ----- hw/rtl/lrast_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lrast_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lrast_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [lrast_pkg::CFG_IDX_BITS-1:0]      index;
    logic [lrast_pkg::FRAME_DIM_BITS-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hw/rtl/lrast_stepper.sv -----
// ----------------------------------------------------------------------------
// lrast_stepper
// Line setup and Bresenham step: holds the line state and the current pixel.
// ----------------------------------------------------------------------------
module lrast_stepper #(
    parameter int COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_opcode,
    input  logic signed [COORD_BITS-1:0]        i_start_x,
    input  logic signed [COORD_BITS-1:0]        i_start_y,
    input  logic signed [COORD_BITS-1:0]        i_end_x,
    input  logic signed [COORD_BITS-1:0]        i_end_y,
    input  logic [lrast_pkg::COLOUR_BITS-1:0]   i_line_colour,
    input  logic                                i_advance,
    output logic                                o_valid,
    output logic signed [COORD_BITS-1:0]        o_x,
    output logic signed [COORD_BITS-1:0]        o_y,
    output logic [lrast_pkg::COLOUR_BITS-1:0]   o_colour,
    output logic                                o_last
);
    localparam int CB = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    // line state
    logic                          r_active;
    logic signed [CB-1:0]          r_cursor_x, n_cursor_x;
    logic signed [CB-1:0]          r_cursor_y, n_cursor_y;
    logic signed [CB-1:0]          r_major_end, n_major_end;
    logic signed [EW-1:0]          r_error, n_error;
    logic [CB-1:0]                 r_abs_dx, n_abs_dx;
    logic [CB-1:0]                 r_abs_dy, n_abs_dy;
    logic                          r_x_major, n_x_major;
    logic                          r_step_up, n_step_up;
    logic [lrast_pkg::COLOUR_BITS-1:0] r_colour, n_colour;
    logic                          r_valid, n_valid;
    logic                          r_last, n_last;
    logic                          n_active;

    // setup terms
    logic signed [CB:0]            dx, dy;
    logic signed [CB:0]            neg_dx, neg_dy;
    logic [CB-1:0]                 s_abs_dx, s_abs_dy;
    logic                          s_x_major;
    // step terms
    logic signed [EW-1:0]          two_dx, two_dy, two_dy_m_dx, two_dx_m_dy;
    logic signed [CB:0]            diff_dy_dx;
    logic [CB-1:0]                 minor_inc;

    // endpoint deltas and octant choice
    always_comb begin
        dx       = {i_end_x[CB-1], i_end_x} - {i_start_x[CB-1], i_start_x};
        dy       = {i_end_y[CB-1], i_end_y} - {i_start_y[CB-1], i_start_y};
        neg_dx   = -dx;
        neg_dy   = -dy;
        s_abs_dx = dx[CB] ? neg_dx[CB-1:0] : dx[CB-1:0];
        s_abs_dy = dy[CB] ? neg_dy[CB-1:0] : dy[CB-1:0];
        s_x_major = s_abs_dy <= s_abs_dx;
    end

    // error increments from the held deltas
    always_comb begin
        two_dx      = $signed({2'b00, r_abs_dx, 1'b0});
        two_dy      = $signed({2'b00, r_abs_dy, 1'b0});
        diff_dy_dx  = $signed({1'b0, r_abs_dy}) - $signed({1'b0, r_abs_dx});
        two_dy_m_dx = $signed({diff_dy_dx[CB], diff_dy_dx, 1'b0});
        two_dx_m_dy = -two_dy_m_dx;
        minor_inc   = r_step_up ? CB'(1) : {CB{1'b1}};
    end

    // next state
    always_comb begin
        n_active    = r_active;
        n_cursor_x  = r_cursor_x;
        n_cursor_y  = r_cursor_y;
        n_major_end = r_major_end;
        n_error     = r_error;
        n_abs_dx    = r_abs_dx;
        n_abs_dy    = r_abs_dy;
        n_x_major   = r_x_major;
        n_step_up   = r_step_up;
        n_colour    = r_colour;
        n_last      = r_last;
        n_valid     = r_valid & ~i_advance;
        if (i_accept) begin
            if (i_opcode == lrast_pkg::OP_START) begin
                n_abs_dx  = s_abs_dx;
                n_abs_dy  = s_abs_dy;
                n_colour  = i_line_colour;
                n_step_up = (dx[CB] && dy[CB]) ||
                            (!dx[CB] && dx != '0 && !dy[CB] && dy != '0);
                n_x_major = s_x_major;
                if (s_x_major) begin
                    if (!dx[CB]) begin
                        n_cursor_x  = i_start_x;
                        n_cursor_y  = i_start_y;
                        n_major_end = i_end_x;
                    end else begin
                        n_cursor_x  = i_end_x;
                        n_cursor_y  = i_end_y;
                        n_major_end = i_start_x;
                    end
                    n_error = $signed({2'b00, s_abs_dy, 1'b0}) -
                              $signed({3'b000, s_abs_dx});
                    n_last  = n_cursor_x >= n_major_end;
                end else begin
                    if (!dy[CB]) begin
                        n_cursor_x  = i_start_x;
                        n_cursor_y  = i_start_y;
                        n_major_end = i_end_y;
                    end else begin
                        n_cursor_x  = i_end_x;
                        n_cursor_y  = i_end_y;
                        n_major_end = i_start_y;
                    end
                    n_error = $signed({2'b00, s_abs_dx, 1'b0}) -
                              $signed({3'b000, s_abs_dy});
                    n_last  = n_cursor_y >= n_major_end;
                end
                n_active = ~n_last;
                n_valid  = 1'b1;
            end else if (r_active) begin
                if (r_x_major) begin
                    n_cursor_x = r_cursor_x + CB'(1);
                    if (r_error[EW-1]) begin
                        n_error = r_error + two_dy;
                    end else begin
                        n_cursor_y = r_cursor_y + minor_inc;
                        n_error    = r_error + two_dy_m_dx;
                    end
                    n_last = n_cursor_x >= r_major_end;
                end else begin
                    n_cursor_y = r_cursor_y + CB'(1);
                    if (r_error[EW-1] || r_error == '0) begin
                        n_error = r_error + two_dx;
                    end else begin
                        n_cursor_x = r_cursor_x + minor_inc;
                        n_error    = r_error + two_dx_m_dy;
                    end
                    n_last = n_cursor_y >= r_major_end;
                end
                n_active = ~n_last;
                n_valid  = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_valid  <= n_valid;
        end
    end

    // line and pixel payload
    always_ff @(posedge i_clk) begin
        r_cursor_x  <= n_cursor_x;
        r_cursor_y  <= n_cursor_y;
        r_major_end <= n_major_end;
        r_error     <= n_error;
        r_abs_dx    <= n_abs_dx;
        r_abs_dy    <= n_abs_dy;
        r_x_major   <= n_x_major;
        r_step_up   <= n_step_up;
        r_colour    <= n_colour;
        r_last      <= n_last;
    end

    assign o_valid  = r_valid;
    assign o_x      = r_cursor_x;
    assign o_y      = r_cursor_y;
    assign o_colour = r_colour;
    assign o_last   = r_last;

endmodule

// ----- hw/rtl/lrast_clip.sv -----
// ----------------------------------------------------------------------------
// lrast_clip
// Frame clipping and address generation, with the output word register.
// ----------------------------------------------------------------------------
module lrast_clip #(
    parameter int COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lrast_pkg::t_frame_cfg               i_frame,
    input  logic                                i_valid,
    input  logic signed [COORD_BITS-1:0]        i_x,
    input  logic signed [COORD_BITS-1:0]        i_y,
    input  logic [lrast_pkg::COLOUR_BITS-1:0]   i_colour,
    input  logic                                i_last,
    output logic                                o_advance,
    lrast_out_if.source                         o_pix
);
    localparam int CB     = COORD_BITS;
    localparam int DB     = lrast_pkg::FRAME_DIM_BITS;
    localparam int CMP_W  = (CB > DB) ? CB : DB;
    localparam int PROD_W = (CB + DB > lrast_pkg::ADDR_BITS) ? CB + DB
                                                              : lrast_pkg::ADDR_BITS;

    logic                          in_frame;
    logic [CMP_W-1:0]              x_ext, y_ext, w_ext, h_ext;
    logic [PROD_W-1:0]             row_base, addr_full;
    logic [lrast_pkg::ADDR_BITS-1:0] addr;

    logic                          r_valid;
    logic                          r_we;
    logic signed [CB-1:0]          r_x, r_y;
    logic [lrast_pkg::ADDR_BITS-1:0] r_addr;
    logic [lrast_pkg::COLOUR_BITS-1:0] r_colour;
    logic                          r_last;

    // in-frame test and row-major address
    always_comb begin
        x_ext     = CMP_W'($unsigned(i_x));
        y_ext     = CMP_W'($unsigned(i_y));
        w_ext     = CMP_W'(i_frame.width);
        h_ext     = CMP_W'(i_frame.height);
        in_frame  = !i_x[CB-1] && !i_y[CB-1] && (x_ext < w_ext) && (y_ext < h_ext);
        row_base  = PROD_W'($unsigned(i_y)) * PROD_W'(i_frame.width);
        addr_full = row_base + PROD_W'($unsigned(i_x));
        addr      = in_frame ? addr_full[lrast_pkg::ADDR_BITS-1:0] : '0;
    end

    // output word moves on when empty or taken
    assign o_advance = !r_valid || o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_we     <= in_frame;
            r_x      <= i_x;
            r_y      <= i_y;
            r_addr   <= addr;
            r_colour <= i_colour;
            r_last   <= i_last;
        end
    end

    assign o_pix.valid         = r_valid;
    assign o_pix.write_enable  = r_we;
    assign o_pix.pixel_x       = r_x;
    assign o_pix.pixel_y       = r_y;
    assign o_pix.pixel_address = r_addr;
    assign o_pix.pixel_colour  = r_colour;
    assign o_pix.last_pixel    = r_last;

endmodule

// ----- hw/rtl/line_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Bresenham line rasterizer producing framebuffer pixel write words.
// ----------------------------------------------------------------------------
// A start word loads two endpoints and a colour and yields the first pixel;
// each tick word yields the next pixel, the one at the end point marked with
// last_pixel, and ticks with no line running yield nothing. One command word
// is taken every clock unless pixel back-pressure stalls it, a rate set by the
// stepper's error update; its pixel is registered after the setup or error-term
// step in the stepper, then after the frame clip and y times width multiply.
// The user must write the frame size registers through the configuration
// channel only while no line is in flight; the block does not enforce this.
module line_rasterizer_core #(
    parameter int COORD_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lrast_in_if.sink      i_in,
    lrast_cfg_if.sink     i_cfg,
    lrast_out_if.source   o_pix
);
    lrast_pkg::t_frame_dim  r_frame_width;
    lrast_pkg::t_frame_dim  r_frame_height;
    lrast_pkg::t_frame_cfg  frame;

    logic                   accept;
    logic                   advance;
    logic                   s1_valid;
    logic signed [COORD_BITS-1:0] s1_x, s1_y;
    logic [lrast_pkg::COLOUR_BITS-1:0] s1_colour;
    logic                   s1_last;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lrast_pkg::FRAME_WIDTH_RESET;
            r_frame_height <= lrast_pkg::FRAME_HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lrast_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                lrast_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign frame.width  = r_frame_width;
    assign frame.height = r_frame_height;

    // command word taken when the step stage is free or moving on
    assign i_in.ready = !s1_valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    lrast_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_opcode      (i_in.opcode),
        .i_start_x     (i_in.start_x),
        .i_start_y     (i_in.start_y),
        .i_end_x       (i_in.end_x),
        .i_end_y       (i_in.end_y),
        .i_line_colour (i_in.line_colour),
        .i_advance     (advance),
        .o_valid       (s1_valid),
        .o_x           (s1_x),
        .o_y           (s1_y),
        .o_colour      (s1_colour),
        .o_last        (s1_last)
    );

    lrast_clip #(
        .COORD_BITS (COORD_BITS)
    ) u_clip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frame   (frame),
        .i_valid   (s1_valid),
        .i_x       (s1_x),
        .i_y       (s1_y),
        .i_colour  (s1_colour),
        .i_last    (s1_last),
        .o_advance (advance),
        .o_pix     (o_pix)
    );

endmodule

// ----- tb/line_rasterizer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_checker
// Watches the command, configuration and pixel channels of the rasterizer,
// predicts each pixel word from the accepted commands and frame size, and
// compares every accepted pixel word field by field in order.
// ----------------------------------------------------------------------------
module line_rasterizer_checker
    import lrast_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lrast_in_if     cmd,
    lrast_cfg_if    cfg,
    lrast_out_if    pix,
    output int      o_errors,
    output int      o_pending,
    output int      o_pixels,
    output int      o_drawn
);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [COORD_BITS+2:0] t_err;
    typedef logic        [COORD_BITS-1:0] t_delta;

    typedef struct packed {
        logic    write_enable;
        t_coord  pixel_x;
        t_coord  pixel_y;
        t_addr   pixel_address;
        t_colour pixel_colour;
        logic    last_pixel;
    } t_pixel_word;

    // pixel words still owed by the block, oldest first
    t_pixel_word expected_pixels[$];

    // frame geometry
    t_frame_dim frame_w = FRAME_WIDTH_RESET;
    t_frame_dim frame_h = FRAME_HEIGHT_RESET;

    // stepper state
    logic    line_active = 1'b0;
    t_coord  cur_x = '0;
    t_coord  cur_y = '0;
    t_coord  major_end = '0;
    t_err    err = '0;
    t_delta  abs_dx = '0;
    t_delta  abs_dy = '0;
    logic    x_major = 1'b0;
    logic    step_up = 1'b0;
    t_colour held_colour = '0;

    int mismatch_count = 0;
    int pixel_count    = 0;
    int drawn_count    = 0;

    // clip the cursor against the frame and queue the pixel word
    function automatic void queue_pixel(input logic last);
        t_pixel_word w;
        logic        in_frame;
        in_frame = cur_x >= 0 && cur_y >= 0 &&
                   int'(cur_x) < int'(frame_w) && int'(cur_y) < int'(frame_h);
        w.write_enable  = in_frame;
        w.pixel_x       = cur_x;
        w.pixel_y       = cur_y;
        w.pixel_address = in_frame ? t_addr'(int'(cur_x) + int'(cur_y) * int'(frame_w)) : '0;
        w.pixel_colour  = held_colour;
        w.last_pixel    = last;
        expected_pixels.push_back(w);
    endfunction

    // start word: pick the octant, order the endpoints, first pixel at once
    function automatic void start_line();
        int   sx, sy, ex, ey, dx, dy;
        logic last;
        sx = int'(cmd.start_x);
        sy = int'(cmd.start_y);
        ex = int'(cmd.end_x);
        ey = int'(cmd.end_y);
        dx = ex - sx;
        dy = ey - sy;
        abs_dx      = t_delta'(dx < 0 ? -dx : dx);
        abs_dy      = t_delta'(dy < 0 ? -dy : dy);
        held_colour = cmd.line_colour;
        step_up     = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
        x_major     = abs_dy <= abs_dx;
        if (x_major) begin
            if (dx >= 0) begin
                cur_x = t_coord'(sx); cur_y = t_coord'(sy); major_end = t_coord'(ex);
            end else begin
                cur_x = t_coord'(ex); cur_y = t_coord'(ey); major_end = t_coord'(sx);
            end
            err  = t_err'(2 * int'(abs_dy) - int'(abs_dx));
            last = cur_x >= major_end;
        end else begin
            if (dy >= 0) begin
                cur_x = t_coord'(sx); cur_y = t_coord'(sy); major_end = t_coord'(ey);
            end else begin
                cur_x = t_coord'(ex); cur_y = t_coord'(ey); major_end = t_coord'(sy);
            end
            err  = t_err'(2 * int'(abs_dx) - int'(abs_dy));
            last = cur_y >= major_end;
        end
        line_active = !last;
        queue_pixel(last);
    endfunction

    // tick word: one step along the major axis by the error-term rule
    function automatic void step_line();
        logic last;
        if (x_major) begin
            cur_x = t_coord'(int'(cur_x) + 1);
            if (err < 0) begin
                err = t_err'(int'(err) + 2 * int'(abs_dy));
            end else begin
                cur_y = t_coord'(int'(cur_y) + (step_up ? 1 : -1));
                err   = t_err'(int'(err) + 2 * (int'(abs_dy) - int'(abs_dx)));
            end
            last = cur_x >= major_end;
        end else begin
            cur_y = t_coord'(int'(cur_y) + 1);
            if (err <= 0) begin
                err = t_err'(int'(err) + 2 * int'(abs_dx));
            end else begin
                cur_x = t_coord'(int'(cur_x) + (step_up ? 1 : -1));
                err   = t_err'(int'(err) + 2 * (int'(abs_dx) - int'(abs_dy)));
            end
            last = cur_y >= major_end;
        end
        line_active = !last;
        queue_pixel(last);
    endfunction

    // compare an accepted pixel word with the oldest expectation
    function automatic void check_pixel();
        t_pixel_word want;
        pixel_count++;
        if (pix.write_enable === 1'b1) drawn_count++;
        if (expected_pixels.size() == 0) begin
            if (mismatch_count < 10)
                $display("%0t: pixel word with nothing expected: x=%0d y=%0d last=%0b",
                         $realtime, pix.pixel_x, pix.pixel_y, pix.last_pixel);
            mismatch_count++;
        end else begin
            want = expected_pixels.pop_front();
            if (pix.write_enable !== want.write_enable || pix.pixel_x !== want.pixel_x ||
                pix.pixel_y !== want.pixel_y || pix.pixel_address !== want.pixel_address ||
                pix.pixel_colour !== want.pixel_colour ||
                pix.last_pixel !== want.last_pixel) begin
                if (mismatch_count < 10) begin
                    $display("%0t: pixel mismatch", $realtime);
                    $display("  expected we=%0b x=%0d y=%0d addr=%h colour=%h last=%0b",
                             want.write_enable, want.pixel_x, want.pixel_y,
                             want.pixel_address, want.pixel_colour, want.last_pixel);
                    $display("  actual   we=%0b x=%0d y=%0d addr=%h colour=%h last=%0b",
                             pix.write_enable, pix.pixel_x, pix.pixel_y,
                             pix.pixel_address, pix.pixel_colour, pix.last_pixel);
                end
                mismatch_count++;
            end
        end
    endfunction

    // sample every channel at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_pixels.delete();
            frame_w     = FRAME_WIDTH_RESET;
            frame_h     = FRAME_HEIGHT_RESET;
            line_active = 1'b0;
            cur_x       = '0;
            cur_y       = '0;
            major_end   = '0;
            err         = '0;
            abs_dx      = '0;
            abs_dy      = '0;
            x_major     = 1'b0;
            step_up     = 1'b0;
            held_colour = '0;
        end else begin
            if (pix.valid && pix.ready) check_pixel();
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_FRAME_WIDTH: begin
                        frame_w = cfg.data;
                    end
                    REG_FRAME_HEIGHT: begin
                        frame_h = cfg.data;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.valid && cmd.ready) begin
                if (cmd.opcode == OP_START) start_line();
                else if (line_active) step_line();
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= expected_pixels.size();
        o_pixels  <= pixel_count;
        o_drawn   <= drawn_count;
    end

endmodule

// ----- tb/line_rasterizer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_core_tb
// Drives start and tick words into the line rasterizer over several frame
// sizes and pacing modes; a checker beside the block predicts and compares
// every pixel word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module line_rasterizer_core_tb;
    import lrast_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LONG_SPAN       = 40;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} t_pace;

    // frame size per phase, phase 0 runs on the reset values
    localparam t_frame_dim PHASE_WIDTH [PHASES] =
        '{FRAME_WIDTH_RESET, 12'd64, 12'd0, 12'd4095, 12'd1, 12'd0, 12'd640, 12'd4095};
    localparam t_frame_dim PHASE_HEIGHT [PHASES] =
        '{FRAME_HEIGHT_RESET, 12'd48, 12'd0, 12'd4095, 12'd1, 12'd0, 12'd4095, 12'd1};

    logic i_clk = 1'b0;
    logic i_rst_n;

    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         words_sent     = 0;
    t_frame_dim cur_width      = FRAME_WIDTH_RESET;
    t_frame_dim cur_height     = FRAME_HEIGHT_RESET;

    int errors, pending, pixels, drawn;

    lrast_in_if  #(.COORD_BITS(COORD_BITS)) cmd_ch ();
    lrast_cfg_if                            cfg_ch ();
    lrast_out_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

    line_rasterizer_core #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_pix   (pix_ch)
    );

    line_rasterizer_checker #(.COORD_BITS(COORD_BITS)) chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cmd       (cmd_ch),
        .cfg       (cfg_ch),
        .pix       (pix_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_pixels  (pixels),
        .o_drawn   (drawn)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // watchdog
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // pixel sink with random back-pressure
    initial begin
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            pix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -(1 << (COORD_BITS - 1))) return -(1 << (COORD_BITS - 1));
        if (v > (1 << (COORD_BITS - 1)) - 1) return (1 << (COORD_BITS - 1)) - 1;
        return v;
    endfunction

    // a coordinate close to the frame border or its middle
    function automatic int near_border(input int dim);
        int base;
        case ($urandom_range(2))
            0: base = 0;
            1: base = dim - 1;
            default: base = dim / 2;
        endcase
        return clamp_coord(base + rand_span(-6, 6));
    endfunction

    task automatic set_pace(input t_pace p);
        case (p)
            PACE_FREE: begin
                send_idle_pct = 0;  recv_stall_pct = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle_pct = 74; recv_stall_pct = 0;
            end
            PACE_RECV_STALL: begin
                send_idle_pct = 0;  recv_stall_pct = 74;
            end
            default: begin
                send_idle_pct = 22; recv_stall_pct = 22;
            end
        endcase
    endtask

    // one command word, with random idle cycles ahead of it
    task automatic put_word(input logic op, input t_coord sx, input t_coord sy,
                            input t_coord ex, input t_coord ey, input t_colour col);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.start_x     <= sx;
        cmd_ch.start_y     <= sy;
        cmd_ch.end_x       <= ex;
        cmd_ch.end_y       <= ey;
        cmd_ch.line_colour <= col;
        words_sent++;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    // tick word, endpoint and colour fields are don't-care
    task automatic put_tick();
        put_word(OP_TICK, t_coord'($urandom), t_coord'($urandom),
                 t_coord'($urandom), t_coord'($urandom), $urandom);
    endtask

    task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                             input t_colour col, input int n_ticks);
        put_word(OP_START, t_coord'(sx), t_coord'(sy), t_coord'(ex), t_coord'(ey), col);
        repeat (n_ticks) put_tick();
    endtask

    // wait until every owed pixel word has arrived, then let the pipe settle
    task automatic drain_pixels();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write both frame size registers back to back
    task automatic set_frame(input t_frame_dim w, input t_frame_dim h);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_FRAME_WIDTH;
        cfg_ch.data  <= w;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.index <= REG_FRAME_HEIGHT;
        cfg_ch.data  <= h;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_width  = w;
        cur_height = h;
    endtask

    // stimulus
    initial begin
        int         sx, sy, ex, ey, span, n_ticks, kind, items;
        t_frame_dim w, h;

        cmd_ch.valid       <= 1'b0;
        cmd_ch.opcode      <= OP_TICK;
        cmd_ch.start_x     <= '0;
        cmd_ch.start_y     <= '0;
        cmd_ch.end_x       <= '0;
        cmd_ch.end_y       <= '0;
        cmd_ch.line_colour <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_FRAME_WIDTH;
        cfg_ch.data        <= '0;
        i_rst_n            <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words on the reset frame size
        set_pace(PACE_FREE);
        put_tick();                                          // tick with no line running
        send_line(0, 0, 0, 0, 32'h0000_0000, 0);             // single point
        send_line(2, 3, 5, 4, 32'hFFFF_FFFF, 4);             // x-major, one extra tick
        send_line(6, 1, 3, 3, 32'h1234_5678, 3);             // x-major, endpoints swapped
        send_line(3, 5, 1, 1, 32'h8765_4321, 4);             // y-major, endpoints swapped
        send_line(-2, -1, 1, 0, 32'h00FF_00FF, 3);           // starts outside the frame
        send_line(-2048, -2048, 2047, 2047, 32'hA5A5_5A5A, 1);
        send_line(2047, 2047, 2047, 2047, 32'h5A5A_A5A5, 0); // restart while busy
        send_line(1279, 719, 1280, 718, 32'hC0DE_F00D, 1);   // across the far corner

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                drain_pixels();
                w = PHASE_WIDTH[ph];
                h = PHASE_HEIGHT[ph];
                if (ph == 5) begin
                    w = t_frame_dim'($urandom_range(1, 4095));
                    h = t_frame_dim'($urandom_range(1, 4095));
                end
                set_frame(w, h);
            end
            set_pace(t_pace'(ph % 4));
            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                kind = $urandom_range(99);
                if (kind < 5) begin
                    // stray ticks
                    repeat ($urandom_range(1, 3)) put_tick();
                    continue;
                end
                if (kind < 60) begin
                    sx = near_border(int'(cur_width));
                    sy = near_border(int'(cur_height));
                    ex = clamp_coord(sx + rand_span(-10, 10));
                    ey = clamp_coord(sy + rand_span(-10, 10));
                end else if (kind < 85) begin
                    sx = int'(t_coord'($urandom));
                    sy = int'(t_coord'($urandom));
                    ex = clamp_coord(sx + rand_span(-12, 12));
                    ey = clamp_coord(sy + rand_span(-12, 12));
                end else begin
                    sx = int'(t_coord'($urandom));
                    sy = int'(t_coord'($urandom));
                    ex = int'(t_coord'($urandom));
                    ey = int'(t_coord'($urandom));
                end
                span = (ex > sx) ? ex - sx : sx - ex;
                if (((ey > sy) ? ey - sy : sy - ey) > span)
                    span = (ey > sy) ? ey - sy : sy - ey;
                // mostly whole lines, some overrun with idle ticks, some cut short
                case ($urandom_range(9))
                    0, 1: n_ticks = $urandom_range(0, span);
                    2:    n_ticks = span + $urandom_range(1, 3);
                    default: n_ticks = span;
                endcase
                if (span > LONG_SPAN) n_ticks = $urandom_range(1, 30);
                send_line(sx, sy, ex, ey, $urandom, n_ticks);
                items += 1 + ((n_ticks < span) ? n_ticks : span);
            end
            // a single point leaves the block idle before the next frame size
            send_line(0, 0, 0, 0, $urandom, 0);
        end
        drain_pixels();

        $display("run covered %0d command words over %0d frame sizes and four pacing modes",
                 words_sent, PHASES);
        $display("%0d pixel words checked, %0d inside the frame", pixels, drawn);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lrast_pkg.sv
hw/rtl/lrast_in_if.sv
hw/rtl/lrast_out_if.sv
hw/rtl/lrast_cfg_if.sv
hw/rtl/lrast_stepper.sv
hw/rtl/lrast_clip.sv
hw/rtl/line_rasterizer_core.sv
tb/line_rasterizer_checker.sv
tb/line_rasterizer_core_tb.sv
